// ===== hw/rtl/rit_pkg.sv =====
package rit_pkg;

   // Fixed field widths of the request and response channels.
   localparam int VALUE_W   = 32;
   localparam int RADIX_W   = 5;
   localparam int FWIDTH_W  = 6;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;

   // Default depth of the digit store.
   localparam int MAX_DIGITS_DEFAULT = 32;

   // Most characters one conversion may emit, and the width of a position.
   localparam int RESULT_LIMIT = 32;
   localparam int POS_W        = $clog2(RESULT_LIMIT);

   // Legal radix range; requests outside it saturate.
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   // The divider retires this many quotient bits per cycle.
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Conversion sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_LOAD,
      ST_SEND
   } state_type;

   // Maps a digit value to its upper-case ASCII character.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] ch;
      if (digit < DIGIT_W'(10)) begin
         ch = CHAR_W'(8'h30) + CHAR_W'(digit);
      end else begin
         ch = CHAR_W'(8'h37) + CHAR_W'(digit);
      end
      return ch;
   endfunction

endpackage

// ===== hw/rtl/rit_if.sv =====
// Request channel: one value to convert with its formatting options.
interface rit_req_if;
   logic                            valid;
   logic                            ready;
   logic [rit_pkg::VALUE_W-1:0]     value;
   logic [rit_pkg::RADIX_W-1:0]     radix;
   logic [rit_pkg::FWIDTH_W-1:0]    field_width;
   logic [rit_pkg::CHAR_W-1:0]      pad_char;

   modport source (output valid, value, radix, field_width, pad_char, input ready);
   modport sink   (input valid, value, radix, field_width, pad_char, output ready);
endinterface

// Response channel: one output character per request on this channel.
interface rit_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rit_pkg::CHAR_W-1:0]      out_char;
   logic                            last;

   modport source (output valid, out_char, last, input ready);
   modport sink   (input valid, out_char, last, output ready);
endinterface

// ===== hw/rtl/radix_integer_to_text_core.sv =====
// Converts a 32-bit unsigned value to ASCII text in radix 2 to 16 (upper-case
// A-F), most significant character first, one character per response request,
// with last set on the final one. A radix outside 2..16 saturates to that range.
// A field width of 0 gives the natural digits, a width up to the digit count
// keeps only the lowest digits, and a larger width pads on the left with the
// pad character (widths above 32 act as 32). The block takes one request at a
// time. A shared long divider retires 8 quotient bits per cycle and yields each
// digit as its remainder; each character then passes a digit store read,
// a format step and a send, the send waiting until the sink is ready.
module radix_integer_to_text_core #(
   parameter int MAX_DIGITS = rit_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   rit_req_if.sink   req_bus,
   rit_rsp_if.source rsp_bus
);
   import rit_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int CMP_W = (CNT_W > FWIDTH_W) ? CNT_W : FWIDTH_W;

   state_type              state_ff, state_in;
   logic [VALUE_W-1:0]     dvd_ff, dvd_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic [FWIDTH_W-1:0]    fwidth_ff, fwidth_in;
   logic [CHAR_W-1:0]      pad_ff, pad_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                   last_ff, last_in;
   logic [DIGIT_W-1:0]     rd_data_ff;
   logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];

   logic                   mem_we;
   logic [DIGIT_W-1:0]     div_rem;
   logic [DIV_BITS-1:0]    div_qbits;
   logic [VALUE_W-1:0]     div_next;

   // Shared divider slice: eight restoring compare-subtract steps on a narrow remainder.
   always_comb begin
      logic [DIGIT_W:0]   trial;
      logic [DIGIT_W-1:0] r;
      r = rem_ff;
      div_qbits = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r, dvd_ff[VALUE_W-1-i]};
         if (trial >= (DIGIT_W+1)'(radix_ff)) begin
            r = DIGIT_W'(trial - (DIGIT_W+1)'(radix_ff));
            div_qbits[DIV_BITS-1-i] = 1'b1;
         end else begin
            r = trial[DIGIT_W-1:0];
         end
      end
      div_rem  = r;
      div_next = {dvd_ff[VALUE_W-DIV_BITS-1:0], div_qbits};
   end

   // Character count using the digit count as it will stand after this cycle.
   function automatic logic [CMP_W-1:0] n_len_next(input logic [CNT_W-1:0] cnt);
      logic [CMP_W-1:0] n;
      if (fwidth_ff == '0) begin
         if (CMP_W'(cnt) > CMP_W'(RESULT_LIMIT)) begin
            n = CMP_W'(RESULT_LIMIT);
         end else begin
            n = CMP_W'(cnt);
         end
      end else begin
         n = CMP_W'(fwidth_ff);
      end
      return n;
   endfunction

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in    = state_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      radix_in    = radix_ff;
      fwidth_in   = fwidth_ff;
      pad_in      = pad_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      out_char_in = out_char_ff;
      last_in     = last_ff;
      mem_we      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               dvd_in   = req_bus.value;
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               pad_in   = req_bus.pad_char;
               if (req_bus.radix < RADIX_MIN) begin
                  radix_in = RADIX_MIN;
               end else if (req_bus.radix > RADIX_MAX) begin
                  radix_in = RADIX_MAX;
               end else begin
                  radix_in = req_bus.radix;
               end
               if (req_bus.field_width > FWIDTH_W'(RESULT_LIMIT)) begin
                  fwidth_in = FWIDTH_W'(RESULT_LIMIT);
               end else begin
                  fwidth_in = req_bus.field_width;
               end
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            dvd_in  = div_next;
            rem_in  = div_rem;
            step_in = step_ff + STEP_W'(1);
            // After the last slice the remainder is the next digit.
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               rem_in = '0;
               if (count_ff < CNT_W'(MAX_DIGITS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (div_next == '0) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // Digit store read of the current position lands next cycle.
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (CMP_W'(pos_ff) >= CMP_W'(count_ff)) begin
               out_char_in = pad_ff;
            end else begin
               out_char_in = digit_char(rd_data_ff);
            end
            last_in  = (pos_ff == '0);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_bus.ready) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff - POS_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The first character sits at the top position of the field.
      if (state_ff == ST_DIVIDE && state_in == ST_FETCH) begin
         pos_in = POS_W'(CMP_W'(n_len_next(count_in)) - CMP_W'(1));
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         rem_ff   <= '0;
         dvd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         dvd_ff   <= dvd_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      fwidth_ff   <= fwidth_in;
      pad_ff      <= pad_in;
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
   end

   // Digit store: one write port from the divider, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[IDX_W'(count_ff)] <= div_rem;
      end
      rd_data_ff <= digit_mem[IDX_W'(pos_ff)];
   end

   // Channel outputs.
   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign rsp_bus.valid    = (state_ff == ST_SEND);
   assign rsp_bus.out_char = out_char_ff;
   assign rsp_bus.last     = last_ff;

endmodule
